[design/psnc_pkg.sv]
// Shared types and constants for the palette shade nearest color block.
// No dependencies; every other file in this folder imports it.
`default_nettype none

package psnc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int SHADE_LEVELS    = 128;

    localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COMP_W    = 8;
    localparam int IDX_W     = 8;
    localparam int LVL_W     = 7;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 2 * COMP_W;

    localparam int SHADE_TOP   = SHADE_LEVELS - 1;
    localparam int PROD_W      = COMP_W + LVL_W;
    localparam int SCALE_SHIFT = 22;
    localparam int SCALE_RECIP = ((1 << SCALE_SHIFT) + SHADE_TOP - 1) / SHADE_TOP;
    localparam int RECIP_W     = $clog2(SCALE_RECIP + 1);
    localparam int MUL_W       = PROD_W + RECIP_W;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_DIRECT = 2'd1;
    localparam logic [1:0] REQ_SHADE  = 2'd2;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [LVL_W-1:0]  shade_level;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic [LVL_W-1:0]  shade_row;
    } out_word_t;

    typedef struct packed {
        logic clear;
        logic feed;
    } srch_ctl_t;

endpackage

`default_nettype wire

[design/psnc_cell.sv]
// One cell of the palette ring: holds one color, loads it, or takes its neighbor's.
// Depends on psnc_pkg.
`default_nettype none

module psnc_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load_en,
    input  wire psnc_pkg::rgb_t load_color,
    input  wire logic           shift_en,
    input  wire psnc_pkg::rgb_t next_color,
    output psnc_pkg::rgb_t      color
);
    import psnc_pkg::*;

    rgb_t color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '0;
        end else if (shift_en) begin
            color_reg <= next_color;
        end else if (load_en) begin
            color_reg <= load_color;
        end
    end

    assign color = color_reg;

endmodule

`default_nettype wire

[design/psnc_scale.sv]
// Two-stage shade scaler: floor(component * level / SHADE_TOP) per component.
// Division by a constant via reciprocal multiply. Depends on psnc_pkg.
`default_nettype none

module psnc_scale (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       go,
    input  wire psnc_pkg::rgb_t             src,
    input  wire logic [psnc_pkg::LVL_W-1:0] level,
    output wire logic                       done,
    output psnc_pkg::rgb_t                  scaled
);
    import psnc_pkg::*;

    function automatic logic [COMP_W-1:0] div_top(input logic [PROD_W-1:0] p);
        logic [MUL_W-1:0] m;
        begin
            m = MUL_W'(p) * MUL_W'(SCALE_RECIP);
            return m[SCALE_SHIFT +: COMP_W];
        end
    endfunction

    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic              v1_reg, v2_reg;
    rgb_t              scaled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= go;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_r_reg       <= PROD_W'(src.red)   * PROD_W'(level);
        prod_g_reg       <= PROD_W'(src.green) * PROD_W'(level);
        prod_b_reg       <= PROD_W'(src.blue)  * PROD_W'(level);
        scaled_reg.red   <= div_top(prod_r_reg);
        scaled_reg.green <= div_top(prod_g_reg);
        scaled_reg.blue  <= div_top(prod_b_reg);
    end

    assign done   = v2_reg;
    assign scaled = scaled_reg;

endmodule

`default_nettype wire

[design/psnc_dist.sv]
// Two-stage squared RGB distance and running minimum, lowest index wins ties.
// Depends on psnc_pkg.
`default_nettype none

module psnc_dist (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire psnc_pkg::srch_ctl_t            ctl,
    input  wire logic [psnc_pkg::PAL_IDX_W-1:0] idx,
    input  wire psnc_pkg::rgb_t                 entry,
    input  wire psnc_pkg::rgb_t                 target,
    output wire logic [psnc_pkg::PAL_IDX_W-1:0] best_idx,
    output wire logic [psnc_pkg::DIST_W-1:0]    best_dist
);
    import psnc_pkg::*;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return SQ_W'(d) * SQ_W'(d);
        end
    endfunction

    logic [SQ_W-1:0]      sq_r_reg, sq_g_reg, sq_b_reg;
    logic [PAL_IDX_W-1:0] idx1_reg;
    logic                 v1_reg;
    logic [PAL_IDX_W-1:0] best_idx_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic [DIST_W-1:0]    sum;

    assign sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_ff @(posedge aclk) begin
        sq_r_reg <= sq_diff(entry.red,   target.red);
        sq_g_reg <= sq_diff(entry.green, target.green);
        sq_b_reg <= sq_diff(entry.blue,  target.blue);
        idx1_reg <= idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '1;
        end else if (ctl.clear) begin
            v1_reg        <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '1;
        end else begin
            v1_reg <= ctl.feed;
            if (v1_reg && (sum < best_dist_reg)) begin
                best_idx_reg  <= idx1_reg;
                best_dist_reg <= sum;
            end
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

    a_min_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.clear |=> best_dist_reg <= $past(best_dist_reg))
        else $error("running minimum increased without clear");

endmodule

`default_nettype wire

[design/palette_shade_nearest_color.sv]
// Top level: palette ring of cells, sequencer, shade scaler, distance search.
// Depends on psnc_pkg, psnc_cell, psnc_scale, psnc_dist.
//
//  channel | dir | handshake        | word
//  s_      | in  | s_valid/s_ready  | in_word_t  (load, direct or shade request)
//  m_      | out | m_valid/m_ready  | out_word_t (index, distance, shade row)
//
// Load and unused requests are taken in idle and need no search. Query time is set
// by the ring, which rotates one entry per cycle past the distance unit (a shade
// query rotates once more to fetch its source). Reset clears the palette to black.
// One request in flight; a finished result waits in the output register while
// the next word is taken.
`default_nettype none

module palette_shade_nearest_color (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output wire logic               s_ready,
    input  wire psnc_pkg::in_word_t s_data,
    output wire logic               m_valid,
    input  wire logic               m_ready,
    output psnc_pkg::out_word_t     m_data
);
    import psnc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_SCALE  = 6'b000100,
        ST_SEARCH = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam logic [PAL_IDX_W-1:0] LAST = PAL_IDX_W'(PALETTE_ENTRIES - 1);

    state_t               state_reg, state_next;
    logic [PAL_IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0]     src_ix_reg;
    logic [LVL_W-1:0]     lvl_reg, row_reg;
    rgb_t                 src_reg, tgt_reg;
    logic                 go_reg;
    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    logic                 accept, load_wr, shift_en, sc_done, cnt_last, out_free;
    logic [LVL_W-1:0]     lvl_sat;
    rgb_t                 scaled, in_color;
    rgb_t                 ring_color [PALETTE_ENTRIES];
    srch_ctl_t            ctl;
    logic [PAL_IDX_W-1:0] best_idx;
    logic [DIST_W-1:0]    best_dist;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_wr  = accept && (s_data.req_type == REQ_LOAD)
                      && (int'(s_data.entry_index) < PALETTE_ENTRIES);
    assign shift_en = (state_reg == ST_FETCH) || (state_reg == ST_SEARCH);
    assign cnt_last = (cnt_reg == LAST);
    assign out_free = !m_valid_reg || m_ready;
    assign lvl_sat  = (int'(s_data.shade_level) > SHADE_TOP) ? LVL_W'(SHADE_TOP)
                                                             : s_data.shade_level;
    assign in_color = '{red: s_data.red, green: s_data.green, blue: s_data.blue};

    for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_ring
        psnc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load_en    (load_wr && (s_data.entry_index == IDX_W'(k))),
            .load_color (in_color),
            .shift_en   (shift_en),
            .next_color (ring_color[(k + 1) % PALETTE_ENTRIES]),
            .color      (ring_color[k])
        );
    end

    psnc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go_reg),
        .src     (src_reg),
        .level   (lvl_reg),
        .done    (sc_done),
        .scaled  (scaled)
    );

    assign ctl.clear = (accept && (s_data.req_type == REQ_DIRECT))
                       || ((state_reg == ST_SCALE) && sc_done);
    assign ctl.feed  = (state_reg == ST_SEARCH);

    psnc_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .idx       (cnt_reg),
        .entry     (ring_color[0]),
        .target    (tgt_reg),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.req_type)
                        REQ_DIRECT: state_next = ST_SEARCH;
                        REQ_SHADE:  state_next = ST_FETCH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH:  if (cnt_last) state_next = ST_SCALE;
            ST_SCALE:  if (sc_done) state_next = ST_SEARCH;
            ST_SEARCH: if (cnt_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= (state_reg == ST_FETCH) && cnt_last;
            if (shift_en) begin
                cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            src_ix_reg <= s_data.entry_index;
            lvl_reg    <= lvl_sat;
            src_reg    <= '0;
            row_reg    <= (s_data.req_type == REQ_SHADE)
                          ? LVL_W'(SHADE_TOP - int'(lvl_sat)) : '0;
            if (s_data.req_type == REQ_DIRECT) begin
                tgt_reg <= in_color;
            end
        end
        if ((state_reg == ST_FETCH) && (IDX_W'(cnt_reg) == src_ix_reg)) begin
            src_reg <= ring_color[0];
        end
        if ((state_reg == ST_SCALE) && sc_done) begin
            tgt_reg <= scaled;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.best_index    <= IDX_W'(best_idx);
            m_data_reg.best_distance <= best_dist;
            m_data_reg.shade_row     <= row_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_search_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) && cnt_last |=> state_reg == ST_DRAIN)
        else $error("search did not end after last entry");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done");

    a_ring_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> cnt_reg == '0)
        else $error("palette ring misaligned while idle");

endmodule

`default_nettype wire
